// ----- sv/md5_pkg.sv -----
// ---------------------------------------------------------------------------
// md5_pkg
// Types, round tables and control program of the MD5 message digest block.
// ---------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int PC_W        = 5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word_a;
      logic [31:0] digest_word_b;
      logic [31:0] digest_word_c;
      logic [31:0] digest_word_d;
   } rsp_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_MARK = 8'h80;

   localparam logic [3:0] LEN_LO_WORD = 4'd14;
   localparam logic [3:0] LEN_HI_WORD = 4'd15;
   localparam logic [5:0] FILL_LAST   = 6'd63;
   localparam logic [5:0] FILL_LEN    = 6'd56;
   localparam logic [5:0] FILL_PRELEN = 6'd55;
   localparam logic [5:0] ROUND_LAST  = 6'd63;

   // micro-operations
   localparam logic [3:0] OP_NOP      = 4'd0;
   localparam logic [3:0] OP_ACCEPT   = 4'd1;
   localparam logic [3:0] OP_PRIME    = 4'd2;
   localparam logic [3:0] OP_ROUND    = 4'd3;
   localparam logic [3:0] OP_ADD      = 4'd4;
   localparam logic [3:0] OP_PUT_MARK = 4'd5;
   localparam logic [3:0] OP_PUT_ZERO = 4'd6;
   localparam logic [3:0] OP_LEN_LO   = 4'd7;
   localparam logic [3:0] OP_LEN_HI   = 4'd8;
   localparam logic [3:0] OP_OUTPUT   = 4'd9;

   // jump conditions
   localparam logic [3:0] C_NEVER      = 4'd0;
   localparam logic [3:0] C_ALWAYS     = 4'd1;
   localparam logic [3:0] C_NOT_LAST   = 4'd2;
   localparam logic [3:0] C_FILL_NZ    = 4'd3;
   localparam logic [3:0] C_FILL_LE56  = 4'd4;
   localparam logic [3:0] C_FILL_EQ56  = 4'd5;
   localparam logic [3:0] C_FILL_NOT63 = 4'd6;
   localparam logic [3:0] C_FILL_NOT55 = 4'd7;
   localparam logic [3:0] C_ROUND_NOT63 = 4'd8;

   // program labels
   localparam logic [PC_W-1:0] L_IDLE    = 5'd0;
   localparam logic [PC_W-1:0] L_RND_A   = 5'd2;
   localparam logic [PC_W-1:0] L_PAD     = 5'd5;
   localparam logic [PC_W-1:0] L_RND_B   = 5'd8;
   localparam logic [PC_W-1:0] L_ZERO_B  = 5'd10;
   localparam logic [PC_W-1:0] L_ZERO_E  = 5'd11;
   localparam logic [PC_W-1:0] L_RND_C   = 5'd13;
   localparam logic [PC_W-1:0] L_ZFILL   = 5'd15;
   localparam logic [PC_W-1:0] L_ZLEN    = 5'd16;
   localparam logic [PC_W-1:0] L_LEN     = 5'd17;
   localparam logic [PC_W-1:0] L_RND_D   = 5'd20;

   typedef struct packed {
      logic [3:0]      op;
      logic [3:0]      cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   function automatic ucode_type md5_ucode(input logic [PC_W-1:0] pc);
      ucode_type u;
      case (pc)
         5'd0:    u = '{OP_ACCEPT,   C_NEVER,       L_PAD};
         5'd1:    u = '{OP_PRIME,    C_NEVER,       L_IDLE};
         5'd2:    u = '{OP_ROUND,    C_ROUND_NOT63, L_RND_A};
         5'd3:    u = '{OP_ADD,      C_NEVER,       L_IDLE};
         5'd4:    u = '{OP_NOP,      C_NOT_LAST,    L_IDLE};
         5'd5:    u = '{OP_PUT_MARK, C_NEVER,       L_IDLE};
         5'd6:    u = '{OP_NOP,      C_FILL_NZ,     L_ZERO_B};
         5'd7:    u = '{OP_PRIME,    C_NEVER,       L_IDLE};
         5'd8:    u = '{OP_ROUND,    C_ROUND_NOT63, L_RND_B};
         5'd9:    u = '{OP_ADD,      C_NEVER,       L_IDLE};
         5'd10:   u = '{OP_NOP,      C_FILL_LE56,   L_ZFILL};
         5'd11:   u = '{OP_PUT_ZERO, C_FILL_NOT63,  L_ZERO_E};
         5'd12:   u = '{OP_PRIME,    C_NEVER,       L_IDLE};
         5'd13:   u = '{OP_ROUND,    C_ROUND_NOT63, L_RND_C};
         5'd14:   u = '{OP_ADD,      C_NEVER,       L_IDLE};
         5'd15:   u = '{OP_NOP,      C_FILL_EQ56,   L_LEN};
         5'd16:   u = '{OP_PUT_ZERO, C_FILL_NOT55,  L_ZLEN};
         5'd17:   u = '{OP_LEN_LO,   C_NEVER,       L_IDLE};
         5'd18:   u = '{OP_LEN_HI,   C_NEVER,       L_IDLE};
         5'd19:   u = '{OP_PRIME,    C_NEVER,       L_IDLE};
         5'd20:   u = '{OP_ROUND,    C_ROUND_NOT63, L_RND_D};
         5'd21:   u = '{OP_ADD,      C_NEVER,       L_IDLE};
         5'd22:   u = '{OP_OUTPUT,   C_ALWAYS,      L_IDLE};
         default: u = '{OP_NOP,      C_ALWAYS,      L_IDLE};
      endcase
      return u;
   endfunction

   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   function automatic logic [3:0] md5_word_idx(input logic [5:0] r);
      logic [3:0] i;
      logic [3:0] idx;
      i = r[3:0];
      case (r[5:4])
         2'd0:    idx = i;
         2'd1:    idx = i * 4'd5 + 4'd1;
         2'd2:    idx = i * 4'd3 + 4'd5;
         default: idx = i * 4'd7;
      endcase
      return idx;
   endfunction

   function automatic logic [4:0] md5_shift(input logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'd0:    s = 5'd7;
         4'd1:    s = 5'd12;
         4'd2:    s = 5'd17;
         4'd3:    s = 5'd22;
         4'd4:    s = 5'd5;
         4'd5:    s = 5'd9;
         4'd6:    s = 5'd14;
         4'd7:    s = 5'd20;
         4'd8:    s = 5'd4;
         4'd9:    s = 5'd11;
         4'd10:   s = 5'd16;
         4'd11:   s = 5'd23;
         4'd12:   s = 5'd6;
         4'd13:   s = 5'd10;
         4'd14:   s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] md5_mix(input logic [1:0] grp, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (grp)
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (b & d) | (c & ~d);
         2'd2:    f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

   function automatic logic [31:0] md5_rotl(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] w;
      w = {v, v} << n;
      return w[63:32];
   endfunction

endpackage

`default_nettype wire

// ----- sv/md5_ram.sv -----
// ---------------------------------------------------------------------------
// md5_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/md5_message_digest.sv -----
// ---------------------------------------------------------------------------
// md5_message_digest
// Byte-serial MD5 digest: packs bytes into a block, runs the compression
// under a microcoded sequencer and pads the final block(s).
// ---------------------------------------------------------------------------
//  channel  | dir | payload              | handshake
//  req_     | in  | md5_pkg::req_type    | req_valid / req_stall
//  rsp_     | out | md5_pkg::rsp_type    | rsp_valid / rsp_stall
//
//  A byte is taken while req_stall is low; a byte that completes a block
//  is followed by prime, 64 rounds, chaining add and end test in the datapath.
//  End of message: padding, length words and one or two compressions.
//  Synchronous reset sets the chaining words and counters; no clearing pass.
//  The digest waits in an output register while rsp_stall is high; a
//  second digest waits for that register to empty.
// ---------------------------------------------------------------------------
`default_nettype none

module md5_message_digest (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire md5_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output md5_pkg::rsp_type      rsp_data
);

   md5_pkg::ucode_type          uc;
   logic [md5_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic [5:0]                  fill_ff, fill_in;
   logic [5:0]                  round_ff, round_in;
   logic [63:0]                 bits_ff, bits_in;
   logic                        last_ff, last_in;
   logic [31:0]                 ch_a_ff, ch_b_ff, ch_c_ff, ch_d_ff;
   logic [31:0]                 ch_a_in, ch_b_in, ch_c_in, ch_d_in;
   logic [31:0]                 wa_ff, wb_ff, wc_ff, wd_ff;
   logic [31:0]                 wa_in, wb_in, wc_in, wd_in;
   logic [31:0]                 asm_ff, asm_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   md5_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                        accepted, cond_true, out_load;
   logic                        put_en;
   logic [7:0]                  put_val;
   logic                        wr_en;
   logic [3:0]                  wr_addr, rd_addr;
   logic [31:0]                 wr_data, rd_data;
   logic [31:0]                 t_sum, b_new;

   md5_ram #(
      .WIDTH (md5_pkg::WORD_W),
      .DEPTH (md5_pkg::BLOCK_WORDS)
   ) u_block (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      uc = md5_pkg::md5_ucode(pc_ff);
      req_stall = (uc.op != md5_pkg::OP_ACCEPT);
      accepted  = req_valid && !req_stall;
      out_load  = (uc.op == md5_pkg::OP_OUTPUT) && !(rsp_valid_ff && rsp_stall);

      case (uc.cond)
         md5_pkg::C_ALWAYS:      cond_true = 1'b1;
         md5_pkg::C_NOT_LAST:    cond_true = !last_ff;
         md5_pkg::C_FILL_NZ:     cond_true = (fill_ff != 6'd0);
         md5_pkg::C_FILL_LE56:   cond_true = (fill_ff <= md5_pkg::FILL_LEN);
         md5_pkg::C_FILL_EQ56:   cond_true = (fill_ff == md5_pkg::FILL_LEN);
         md5_pkg::C_FILL_NOT63:  cond_true = (fill_ff != md5_pkg::FILL_LAST);
         md5_pkg::C_FILL_NOT55:  cond_true = (fill_ff != md5_pkg::FILL_PRELEN);
         md5_pkg::C_ROUND_NOT63: cond_true = (round_ff != md5_pkg::ROUND_LAST);
         default:                cond_true = 1'b0;
      endcase

      case (uc.op)
         md5_pkg::OP_ACCEPT: begin
            if (!accepted) begin
               pc_in = pc_ff;
            end else if (req_data.byte_present && fill_ff == md5_pkg::FILL_LAST) begin
               pc_in = pc_ff + 5'd1;
            end else if (req_data.end_of_message) begin
               pc_in = uc.target;
            end else begin
               pc_in = pc_ff;
            end
         end
         md5_pkg::OP_OUTPUT: begin
            pc_in = out_load ? uc.target : pc_ff;
         end
         default: begin
            pc_in = cond_true ? uc.target : pc_ff + 5'd1;
         end
      endcase

      // byte packing
      put_en  = (accepted && req_data.byte_present)
                || uc.op == md5_pkg::OP_PUT_MARK || uc.op == md5_pkg::OP_PUT_ZERO;
      case (uc.op)
         md5_pkg::OP_ACCEPT:   put_val = req_data.data_byte;
         md5_pkg::OP_PUT_MARK: put_val = md5_pkg::PAD_MARK;
         default:              put_val = 8'd0;
      endcase
      if (fill_ff[1:0] == 2'b00) begin
         asm_in = {24'd0, put_val};
      end else begin
         asm_in = asm_ff | ({24'd0, put_val} << {fill_ff[1:0], 3'b000});
      end
      if (!put_en) begin
         asm_in = asm_ff;
      end

      wr_en   = (put_en && fill_ff[1:0] == 2'b11)
                || uc.op == md5_pkg::OP_LEN_LO || uc.op == md5_pkg::OP_LEN_HI;
      case (uc.op)
         md5_pkg::OP_LEN_LO: begin
            wr_addr = md5_pkg::LEN_LO_WORD;
            wr_data = bits_ff[31:0];
         end
         md5_pkg::OP_LEN_HI: begin
            wr_addr = md5_pkg::LEN_HI_WORD;
            wr_data = bits_ff[63:32];
         end
         default: begin
            wr_addr = fill_ff[5:2];
            wr_data = asm_in;
         end
      endcase

      fill_in = fill_ff;
      if (put_en) begin
         fill_in = fill_ff + 6'd1;
      end else if (uc.op == md5_pkg::OP_LEN_HI) begin
         fill_in = 6'd0;
      end

      bits_in = bits_ff;
      last_in = last_ff;
      if (accepted) begin
         last_in = req_data.end_of_message;
         if (req_data.byte_present) begin
            bits_in = bits_ff + 64'd8;
         end
      end

      // compression round
      rd_addr  = (uc.op == md5_pkg::OP_PRIME) ? md5_pkg::md5_word_idx(6'd0)
                                              : md5_pkg::md5_word_idx(round_ff + 6'd1);
      t_sum    = wa_ff + md5_pkg::md5_mix(round_ff[5:4], wb_ff, wc_ff, wd_ff)
                 + md5_pkg::SINE_K[round_ff] + rd_data;
      b_new    = wb_ff + md5_pkg::md5_rotl(t_sum, md5_pkg::md5_shift(round_ff));
      round_in = round_ff;
      wa_in = wa_ff;
      wb_in = wb_ff;
      wc_in = wc_ff;
      wd_in = wd_ff;
      ch_a_in = ch_a_ff;
      ch_b_in = ch_b_ff;
      ch_c_in = ch_c_ff;
      ch_d_in = ch_d_ff;
      case (uc.op)
         md5_pkg::OP_PRIME: begin
            round_in = 6'd0;
            wa_in = ch_a_ff;
            wb_in = ch_b_ff;
            wc_in = ch_c_ff;
            wd_in = ch_d_ff;
         end
         md5_pkg::OP_ROUND: begin
            round_in = round_ff + 6'd1;
            wa_in = wd_ff;
            wd_in = wc_ff;
            wc_in = wb_ff;
            wb_in = b_new;
         end
         md5_pkg::OP_ADD: begin
            ch_a_in = ch_a_ff + wa_ff;
            ch_b_in = ch_b_ff + wb_ff;
            ch_c_in = ch_c_ff + wc_ff;
            ch_d_in = ch_d_ff + wd_ff;
         end
         default: begin
         end
      endcase

      // result register; chaining state restarts for the next message
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{ch_a_ff, ch_b_ff, ch_c_ff, ch_d_ff};
         ch_a_in = md5_pkg::INIT_A;
         ch_b_in = md5_pkg::INIT_B;
         ch_c_in = md5_pkg::INIT_C;
         ch_d_in = md5_pkg::INIT_D;
         bits_in = 64'd0;
         fill_in = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= md5_pkg::L_IDLE;
         fill_ff      <= 6'd0;
         round_ff     <= 6'd0;
         bits_ff      <= 64'd0;
         last_ff      <= 1'b0;
         ch_a_ff      <= md5_pkg::INIT_A;
         ch_b_ff      <= md5_pkg::INIT_B;
         ch_c_ff      <= md5_pkg::INIT_C;
         ch_d_ff      <= md5_pkg::INIT_D;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         fill_ff      <= fill_in;
         round_ff     <= round_in;
         bits_ff      <= bits_in;
         last_ff      <= last_in;
         ch_a_ff      <= ch_a_in;
         ch_b_ff      <= ch_b_in;
         ch_c_ff      <= ch_c_in;
         ch_d_ff      <= ch_d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff       <= wa_in;
      wb_ff       <= wb_in;
      wc_ff       <= wc_in;
      wd_ff       <= wd_in;
      asm_ff      <= asm_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- sv/md5_checker.sv -----
// ---------------------------------------------------------------------------
// md5_checker
// Port-level checks on the MD5 digest block, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

module md5_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire md5_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire md5_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled digest changed or dropped");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("digest valid straight after reset");

   a_busy_before_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("digest appeared while requests were open");

   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.end_of_message |=> req_stall ##64 req_stall)
      else $error("request taken during final compression");

endmodule

bind md5_message_digest md5_checker u_md5_checker (.*);

`default_nettype wire
